@@ design/lst_pkg.sv @@
// Shared types and constants for the indexed list buffer.
package lst_pkg;

   // Default sizing of the list.
   localparam int DEPTH_DEF = 64;
   localparam int WIDTH_DEF = 32;

   // Fixed field widths of the stream words.
   localparam int CMD_W       = 3;
   localparam int INDEX_W     = 6;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   // Command codes carried in the request word.
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_GET    = 3'd2,
      CMD_SET    = 3'd3,
      CMD_SWAP   = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   // Status codes carried in the response word.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Operation that the whole cell row performs together.
   typedef enum logic [2:0] {
      OP_NOP    = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_SET    = 3'd3,
      OP_SWAP   = 3'd4
   } cell_op_type;

endpackage

@@ design/lst_cell.sv @@
// One storage cell of the list: holds the entry at a fixed position.
module lst_cell
   import lst_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEF,
   parameter int IDX_W = 6,
   parameter int POS   = 0
) (
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [IDX_W-1:0]  idx,
   input  logic [IDX_W-1:0]  idx2,
   input  logic [IDX_W-1:0]  rd_idx,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [WIDTH-1:0]  hold_data,
   input  logic [WIDTH-1:0]  left_val,
   input  logic [WIDTH-1:0]  right_val,
   output logic [WIDTH-1:0]  val,
   output logic [WIDTH-1:0]  rd_val
);

   localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;

   // Decide locally what this cell takes in this cycle.
   always_comb begin
      value_in = value_ff;
      case (op)
         OP_INSERT: begin
            if (MY_POS == idx) begin
               value_in = wr_data;
            end else if (MY_POS > idx) begin
               value_in = left_val;
            end
         end
         OP_REMOVE: begin
            if (MY_POS >= idx) begin
               value_in = right_val;
            end
         end
         OP_SET: begin
            if (MY_POS == idx) begin
               value_in = wr_data;
            end
         end
         OP_SWAP: begin
            // The second position wins when both positions are equal.
            if (MY_POS == idx2) begin
               value_in = hold_data;
            end else if (MY_POS == idx) begin
               value_in = wr_data;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign val    = value_ff;
   assign rd_val = (MY_POS == rd_idx) ? value_ff : '0;

endmodule

@@ design/lst_chain.sv @@
// Row of list cells with neighbor links and a shared read bus.
module lst_chain
   import lst_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int WIDTH = WIDTH_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [IDX_W-1:0]  idx,
   input  logic [IDX_W-1:0]  idx2,
   input  logic [IDX_W-1:0]  rd_idx,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [WIDTH-1:0]  hold_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] cell_val [DEPTH];
   logic [WIDTH-1:0] cell_rd  [DEPTH];

   // Each cell sees its left and right neighbor; the ends see zero and themselves.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] left_val;
      logic [WIDTH-1:0] right_val;

      if (i == 0) begin : g_first
         assign left_val = '0;
      end else begin : g_inner_l
         assign left_val = cell_val[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_val = cell_val[i];
      end else begin : g_inner_r
         assign right_val = cell_val[i+1];
      end

      lst_cell #(
         .WIDTH (WIDTH),
         .IDX_W (IDX_W),
         .POS   (i)
      ) u_cell (
         .clock     (clock),
         .op        (op),
         .idx       (idx),
         .idx2      (idx2),
         .rd_idx    (rd_idx),
         .wr_data   (wr_data),
         .hold_data (hold_data),
         .left_val  (left_val),
         .right_val (right_val),
         .val       (cell_val[i]),
         .rd_val    (cell_rd[i])
      );
   end

   // Only the addressed cell drives a nonzero word, so the bus is an OR.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_data = rd_data | cell_rd[i];
      end
   end

endmodule

@@ design/indexed_list_buffer_top.sv @@
// Top level of the indexed list buffer: command sequencer, count and response register.
//
// The list lives in a row of DEPTH cells, one entry per cell; insert and remove
// shift all later cells by one position together. A command is registered when it
// is taken and then executed: get, set, insert, remove and clear finish in the
// exec state, and swap goes on to a swap state, the extra step coming from the
// single read bus along the cell row, which reads one position per cycle. One
// command is in flight at a time; a finished response waits in its own
// register, so the next command is accepted while it is still pending, and
// execution only stalls when a new response is ready and the old one has not
// been taken. Reset needs no clearing pass.
module indexed_list_buffer_top
   import lst_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int WIDTH = WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0: cmd[2:0], index[8:3], second_index[14:9], data[46:15], zero pad.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: out_data[31:0], count[38:32], empty_res[39], status[41:40], zero pad.
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int CMP_W = LEN_W + INDEX_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SWAP = 3'b100
   } state_type;

   state_type            state_ff,  state_in;
   logic [CMD_W-1:0]     cmd_ff,    cmd_in;
   logic [INDEX_W-1:0]   index_ff,  index_in;
   logic [INDEX_W-1:0]   index2_ff, index2_in;
   logic [DATA_W-1:0]    data_ff,   data_in;
   logic [WIDTH-1:0]     hold_ff,   hold_in;
   logic [LEN_W-1:0]     length_ff, length_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_data_ff,  rsp_data_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   status_type           rsp_status_ff, rsp_status_in;

   cell_op_type          op;
   logic [IDX_W-1:0]     idx_cell;
   logic [IDX_W-1:0]     idx2_cell;
   logic [IDX_W-1:0]     rd_idx;
   logic [WIDTH-1:0]     wr_data;
   logic [WIDTH-1:0]     data_cell;
   logic [WIDTH-1:0]     rd_data;
   logic [DATA_W-1:0]    rd_data_out;
   logic [COUNT_W-1:0]   count_out;

   logic [IDX_W+INDEX_W-1:0]  idx_wide;
   logic [IDX_W+INDEX_W-1:0]  idx2_wide;
   logic [WIDTH+DATA_W-1:0]   data_wide;
   logic [WIDTH+DATA_W-1:0]   rd_wide;
   logic [LEN_W+COUNT_W-1:0]  len_wide;

   logic [CMP_W-1:0]     idx_cmp;
   logic [CMP_W-1:0]     idx2_cmp;
   logic [CMP_W-1:0]     len_cmp;
   logic                 idx_in_list;
   logic                 idx2_in_list;
   logic                 list_full;
   logic                 out_free;
   logic                 accept;
   status_type           status;

   // Width conversions between the fixed word fields and the sized storage.
   assign idx_wide    = {{IDX_W{1'b0}}, index_ff};
   assign idx2_wide   = {{IDX_W{1'b0}}, index2_ff};
   assign idx_cell    = idx_wide[IDX_W-1:0];
   assign idx2_cell   = idx2_wide[IDX_W-1:0];
   assign data_wide   = {{WIDTH{1'b0}}, data_ff};
   assign data_cell   = data_wide[WIDTH-1:0];
   assign rd_wide     = {{DATA_W{1'b0}}, rd_data};
   assign rd_data_out = rd_wide[DATA_W-1:0];

   // Range checks against the current count.
   assign idx_cmp      = CMP_W'(index_ff);
   assign idx2_cmp     = CMP_W'(index2_ff);
   assign len_cmp      = CMP_W'(length_ff);
   assign idx_in_list  = idx_cmp < len_cmp;
   assign idx2_in_list = idx2_cmp < len_cmp;
   assign list_full    = length_ff == LEN_W'(DEPTH);

   always_comb begin
      status = STATUS_OK;
      case (cmd_ff)
         CMD_INSERT: begin
            if (idx_cmp > len_cmp) begin
               status = STATUS_RANGE;
            end else if (list_full) begin
               status = STATUS_FULL;
            end
         end
         CMD_REMOVE, CMD_GET, CMD_SET: begin
            if (!idx_in_list) begin
               status = STATUS_RANGE;
            end
         end
         CMD_SWAP: begin
            if (!idx_in_list || !idx2_in_list) begin
               status = STATUS_RANGE;
            end
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;

   // Sequencer: pick the cell operation and build the response.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      index_in      = index_ff;
      index2_in     = index2_ff;
      data_in       = data_ff;
      hold_in       = hold_ff;
      length_in     = length_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      op            = OP_NOP;
      rd_idx        = idx_cell;
      wr_data       = data_cell;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_tdata[CMD_W-1:0];
               index_in  = req_tdata[CMD_W +: INDEX_W];
               index2_in = req_tdata[CMD_W+INDEX_W +: INDEX_W];
               data_in   = req_tdata[CMD_W+2*INDEX_W +: DATA_W];
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd_ff == CMD_SWAP && status == STATUS_OK) begin
               // First half of a swap: latch the entry at the first position.
               hold_in  = rd_data;
               state_in = ST_SWAP;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status;
               rsp_data_in   = '0;
               state_in      = ST_IDLE;
               if (status == STATUS_OK) begin
                  case (cmd_ff)
                     CMD_INSERT: begin
                        op        = OP_INSERT;
                        length_in = length_ff + 1'b1;
                     end
                     CMD_REMOVE: begin
                        op          = OP_REMOVE;
                        rsp_data_in = rd_data_out;
                        length_in   = length_ff - 1'b1;
                     end
                     CMD_GET: begin
                        rsp_data_in = rd_data_out;
                     end
                     CMD_SET: begin
                        op          = OP_SET;
                        rsp_data_in = rd_data_out;
                     end
                     CMD_CLEAR: begin
                        length_in = '0;
                     end
                     default: begin
                        op = OP_NOP;
                     end
                  endcase
               end
            end
         end
         ST_SWAP: begin
            // Second half: read the second position and write both cells.
            rd_idx  = idx2_cell;
            wr_data = rd_data;
            if (out_free) begin
               op            = OP_SWAP;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_data_in   = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Count and empty flag always reflect the count after the command.
   assign len_wide     = {{COUNT_W{1'b0}}, length_in};
   assign count_out    = len_wide[COUNT_W-1:0];
   assign rsp_count_in = (state_in == ST_IDLE && state_ff != ST_IDLE) ? count_out
                                                                       : rsp_count_ff;
   assign rsp_empty_in = (state_in == ST_IDLE && state_ff != ST_IDLE) ? (length_in == '0)
                                                                       : rsp_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      index_ff      <= index_in;
      index2_ff     <= index2_in;
      data_ff       <= data_in;
      hold_ff       <= hold_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   lst_chain #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .IDX_W (IDX_W)
   ) u_chain (
      .clock     (clock),
      .op        (op),
      .idx       (idx_cell),
      .idx2      (idx2_cell),
      .rd_idx    (rd_idx),
      .wr_data   (wr_data),
      .hold_data (hold_ff),
      .rd_data   (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DATA_W-COUNT_W-1-STATUS_W){1'b0}},
                        rsp_status_ff, rsp_empty_ff, rsp_count_ff, rsp_data_ff};

endmodule

@@ design/lst_checker.sv @@
// Port-level checks for the indexed list buffer, bound to the top level.
module lst_checker
   import lst_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [COUNT_W-1:0]  rsp_count;
   logic                rsp_empty;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_data;

   assign rsp_data   = rsp_tdata[DATA_W-1:0];
   assign rsp_count  = rsp_tdata[DATA_W +: COUNT_W];
   assign rsp_empty  = rsp_tdata[DATA_W+COUNT_W];
   assign rsp_status = rsp_tdata[DATA_W+COUNT_W+1 +: STATUS_W];

   // A pending response word is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word dropped or changed while stalled");

   // The empty flag agrees with the count.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_empty == (rsp_count == '0))
      else $error("empty flag disagrees with count");

   // A rejected command returns no data; the count never exceeds the depth when the depth fits the count field.
   a_reject_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != STATUS_W'(STATUS_OK) |-> rsp_data == '0)
      else $error("rejected command returned data");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DEPTH > 127) || (int'(rsp_count) <= DEPTH))
      else $error("count above depth");

   // Reset leaves no response pending and the block ready for a command.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("response or busy state survived reset");

endmodule

bind indexed_list_buffer_top lst_checker #(.DEPTH(DEPTH)) u_lst_checker (.*);
